### sv/grouped_euclidean_distance_ranker_macros.svh
// Assertion macros for the grouped Euclidean distance ranker.
// Used by the controller; no other dependencies.
`ifndef GROUPED_EUCLIDEAN_DISTANCE_RANKER_MACROS_SVH
`define GROUPED_EUCLIDEAN_DISTANCE_RANKER_MACROS_SVH
// Assert an implication that holds at every clock edge outside reset.
`define GED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert an implication whose consequent holds in the cycle after the antecedent.
`define GED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/ged_pkg.sv
// Shared types and constants of the grouped Euclidean distance ranker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ged_pkg;
  localparam int MaxItemsDef = 1024;
  localparam int ValW = 16;
  localparam int ElemsPerGene = 18;
  localparam int DistW = 19;
  localparam int IdxW = 10;
  localparam int CntW = 11;
  localparam int SqW = 36;
  localparam int RootW = 18;
  localparam logic [DistW-1:0] DistMax = 19'h7FFFF;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTRUN  = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic CFG_REF = 1'b0;
  localparam logic CFG_CNT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_acc;     // start a new gene: clear group sum and total
    logic elem_rd;     // issue a read of element pair at elem_idx
    logic sq_acc;      // add squared difference of the returned pair
    logic root_start;  // start square root on the group sum
    logic root_step;   // one root iteration
    logic root_add;    // add finished root into total
    logic ins_start;   // begin insertion at position gene
    logic ins_rd;      // read sorted entry j-1
    logic ins_shift;   // move entry j-1 to j, j--
    logic ins_put;     // write new entry at j
  } ged_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ins_stop;    // j == 0 or entry j-1 <= d
  } ged_sts_t;
endpackage
`default_nettype wire

### sv/grouped_euclidean_distance_ranker.sv
// Top level of the grouped Euclidean distance ranker.
// Depends on ged_pkg, ged_ctrl and ged_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Load requests and rejected requests answer in the cycle after acceptance; a
// good read passes through the read state first. A run request walks every gene
// one vector element at a time (read, wait, accumulate) through the vector memory,
// takes three 18-step square roots, then inserts the gene into the sorted stores,
// reading and checking each entry that it shifts. One request is in flight at a
// time; the next is taken once the result has been delivered.
module grouped_euclidean_distance_ranker #(
  parameter int MAX_ITEMS = ged_pkg::MaxItemsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // req_type[1:0], gene_index[11:2], group[13:12], value0..value5[109:14], rank[119:110]
  input  wire logic [119:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], gene_out[11:2], distance[30:12]
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata
);
  import ged_pkg::*;
  localparam int GW = $clog2(MAX_ITEMS);

  logic [9:0]  ref_r;
  logic [10:0] cnt_r;
  ged_cmd_t cmd;
  ged_sts_t sts;
  logic ld_we;
  logic [GW-1:0] gene, ref_gene, rd_rank, rd_gene;
  logic [4:0] elem_idx;
  logic [DistW-1:0] rd_dist, res_dist;
  logic [1:0] res_status;
  logic [9:0] res_gene;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0; cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF: ref_r <= cfg_wdata[9:0];
        CFG_CNT: cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ged_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk, .rst_n, .req_valid(in_tvalid), .req_ready(in_tready),
    .req_type(in_tdata[1:0]), .req_gene(in_tdata[11:2]), .req_group(in_tdata[13:12]),
    .req_rank(in_tdata[119:110]), .ref_index(ref_r), .gene_count(cnt_r),
    .cmd, .sts, .ld_we, .gene, .ref_gene, .elem_idx, .rd_rank, .rd_gene, .rd_dist,
    .res_valid(out_tvalid), .res_ready(out_tready), .res_status, .res_gene, .res_dist
  );

  ged_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk, .cmd, .sts, .ld_we, .ld_gene(GW'(in_tdata[11:2])), .ld_group(in_tdata[13:12]),
    .ld_vals(in_tdata[109:14]), .gene, .ref_gene, .elem_idx, .rd_rank, .rd_gene, .rd_dist
  );

  assign out_tdata = {1'b0, res_dist, res_gene, res_status};
endmodule
`default_nettype wire

### sv/ged_datapath.sv
// Datapath of the ranker: vector memory, distance arithmetic and sorted stores.
// Depends on ged_pkg; sequenced by ged_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ged_datapath #(
  parameter int MAX_ITEMS = ged_pkg::MaxItemsDef,
  parameter int GW = $clog2(MAX_ITEMS),
  parameter int AW = $clog2(MAX_ITEMS * 3)
) (
  input  wire logic                       clk,
  input  wire ged_pkg::ged_cmd_t          cmd,
  output ged_pkg::ged_sts_t               sts,
  input  wire logic                       ld_we,
  input  wire logic [GW-1:0]              ld_gene,
  input  wire logic [1:0]                 ld_group,
  input  wire logic [6*ged_pkg::ValW-1:0] ld_vals,
  input  wire logic [GW-1:0]              gene,
  input  wire logic [GW-1:0]              ref_gene,
  input  wire logic [4:0]                 elem_idx,
  input  wire logic [GW-1:0]              rd_rank,
  output logic [GW-1:0]                   rd_gene,
  output logic [ged_pkg::DistW-1:0]       rd_dist
);
  import ged_pkg::*;

  // one word per gene and group, six elements wide
  logic [6*ValW-1:0] vmem [MAX_ITEMS*3];
  logic [DistW-1:0] dmem [MAX_ITEMS];
  logic [GW-1:0]    omem [MAX_ITEMS];
  logic [6*ValW-1:0] wa_r, wb_r;
  logic [ValW-1:0]  va, vb;
  logic [SqW-1:0]   sum_r, x_r;
  logic [SqW-1:0]   res_r;
  logic [SqW-1:0]   bit_r;
  logic [DistW+2:0] tot_r;
  logic [DistW-1:0] d_sat, prev_d_r;
  logic [GW-1:0]    prev_o_r;
  logic [GW:0]      j_r;
  logic [AW-1:0]    a_addr, b_addr;
  logic [1:0]       grp_sel;
  logic [2:0]       k_sel;
  logic signed [ValW:0] diff;
  logic signed [2*ValW+1:0] dx;
  logic [2*ValW+1:0]   sq;
  logic [SqW-1:0]      trial;
  logic rd_sel_r;

  // split the element index into group and position within the group
  always_comb begin
    if (elem_idx >= 5'd12) begin
      grp_sel = 2'd2;
      k_sel = 3'(elem_idx - 5'd12);
    end else if (elem_idx >= 5'd6) begin
      grp_sel = 2'd1;
      k_sel = 3'(elem_idx - 5'd6);
    end else begin
      grp_sel = 2'd0;
      k_sel = 3'(elem_idx);
    end
  end

  assign a_addr = AW'(gene) * AW'(3) + AW'(grp_sel);
  assign b_addr = AW'(ref_gene) * AW'(3) + AW'(grp_sel);

  always_ff @(posedge clk) begin
    if (ld_we) begin
      vmem[AW'(ld_gene) * AW'(3) + AW'(ld_group)] <= ld_vals;
    end
  end

  // the memory is taken in two reads, one per cycle: gene word, then reference word
  always_ff @(posedge clk) begin
    if (cmd.elem_rd) begin
      wa_r <= vmem[a_addr];
      rd_sel_r <= 1'b1;
    end else if (rd_sel_r) begin
      wb_r <= vmem[b_addr];
      rd_sel_r <= 1'b0;
    end
  end

  assign va = wa_r[ValW*k_sel +: ValW];
  assign vb = wb_r[ValW*k_sel +: ValW];

  assign diff = $signed({va[ValW-1], va}) - $signed({vb[ValW-1], vb});
  assign dx = {{(ValW+1){diff[ValW]}}, diff};
  assign sq = $unsigned(dx * dx);
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      sum_r <= '0;
      tot_r <= '0;
    end else if (cmd.root_add) begin
      tot_r <= tot_r + (DistW+3)'(res_r);
      sum_r <= '0;
    end else if (cmd.sq_acc) begin
      sum_r <= sum_r + SqW'(sq);
    end
    if (cmd.root_start) begin
      x_r <= sum_r;
      res_r <= '0;
      bit_r <= SqW'(1) << (SqW - 2);
    end else if (cmd.root_step) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign d_sat = (tot_r > (DistW+3)'(DistMax)) ? DistMax : tot_r[DistW-1:0];

  // insertion step: registered read of entry j-1
  always_ff @(posedge clk) begin
    if (cmd.ins_start) j_r <= (GW+1)'(gene);
    else if (cmd.ins_shift) j_r <= j_r - 1'b1;
    if (cmd.ins_rd) begin
      prev_d_r <= dmem[GW'(j_r - 1'b1)];
      prev_o_r <= omem[GW'(j_r - 1'b1)];
    end
    if (cmd.ins_shift) begin
      dmem[GW'(j_r)] <= prev_d_r;
      omem[GW'(j_r)] <= prev_o_r;
    end else if (cmd.ins_put) begin
      dmem[GW'(j_r)] <= d_sat;
      omem[GW'(j_r)] <= gene;
    end
  end

  assign sts.ins_stop = (j_r == '0) || (prev_d_r <= d_sat);

  always_ff @(posedge clk) begin
    rd_gene <= omem[rd_rank];
    rd_dist <= dmem[rd_rank];
  end
endmodule
`default_nettype wire

### sv/ged_ctrl.sv
// Controller of the ranker: request decode, run sequencing, result register.
// Depends on ged_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "grouped_euclidean_distance_ranker_macros.svh"
module ged_ctrl #(
  parameter int MAX_ITEMS = ged_pkg::MaxItemsDef,
  parameter int GW = $clog2(MAX_ITEMS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [1:0]           req_type,
  input  wire logic [9:0]           req_gene,
  input  wire logic [1:0]           req_group,
  input  wire logic [9:0]           req_rank,
  input  wire logic [9:0]           ref_index,
  input  wire logic [10:0]          gene_count,
  output ged_pkg::ged_cmd_t         cmd,
  input  wire ged_pkg::ged_sts_t    sts,
  output logic                      ld_we,
  output logic [GW-1:0]             gene,
  output logic [GW-1:0]             ref_gene,
  output logic [4:0]                elem_idx,
  output logic [GW-1:0]             rd_rank,
  input  wire logic [GW-1:0]        rd_gene,
  input  wire logic [ged_pkg::DistW-1:0] rd_dist,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [1:0]                res_status,
  output logic [9:0]                res_gene,
  output logic [ged_pkg::DistW-1:0] res_dist
);
  import ged_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_RST   = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_RADD  = 4'd6;
  localparam logic [3:0] S_IRD   = 4'd7;
  localparam logic [3:0] S_ICHK  = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_START = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [4:0]    elem_r, elem_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [GW-1:0] gene_r, gene_nxt;
  logic [GW:0]   n_r, n_nxt;
  logic [GW:0]   ranked_r, ranked_nxt;
  logic          sorted_r, sorted_nxt;
  logic          vld_r, vld_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [9:0]    go_r, go_nxt;
  logic [DistW-1:0] do_r, do_nxt;
  logic          acc;
  logic [GW:0]   n_eff;

  assign req_ready = (state_r == S_IDLE) && !vld_r;
  assign acc = req_valid && req_ready;
  assign n_eff = (32'(gene_count) > 32'(MAX_ITEMS)) ? (GW+1)'(MAX_ITEMS) : (GW+1)'(gene_count);
  assign gene = gene_r;
  assign ref_gene = GW'(ref_index);
  assign elem_idx = elem_r;
  assign rd_rank = GW'(req_rank);
  assign ld_we = acc && (req_type == REQ_LOAD) && (32'(req_gene) < 32'(MAX_ITEMS))
                 && (req_group != 2'd3);
  assign res_valid = vld_r;
  assign res_status = st_r;
  assign res_gene = go_r;
  assign res_dist = do_r;

  always_comb begin
    state_nxt = state_r; elem_nxt = elem_r; step_nxt = step_r; gene_nxt = gene_r;
    n_nxt = n_r; ranked_nxt = ranked_r; sorted_nxt = sorted_r;
    vld_nxt = vld_r; st_nxt = st_r; go_nxt = go_r; do_nxt = do_r;
    cmd = '0;
    if (vld_r && res_ready) vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          go_nxt = '0; do_nxt = '0; st_nxt = ST_RANGE;
          case (req_type)
            REQ_LOAD: begin
              st_nxt = ld_we ? ST_OK : ST_RANGE;
              vld_nxt = 1'b1;
            end
            REQ_RUN: begin
              if (32'(ref_index) < 32'(n_eff)) begin
                n_nxt = n_eff; gene_nxt = '0; state_nxt = S_START;
              end else vld_nxt = 1'b1;
            end
            REQ_READ: begin
              if (!sorted_r) begin st_nxt = ST_NOTRUN; vld_nxt = 1'b1; end
              else if (32'(req_rank) < 32'(ranked_r)) state_nxt = S_READ;
              else vld_nxt = 1'b1;
            end
            default: vld_nxt = 1'b1;
          endcase
        end
      end
      S_READ: begin
        st_nxt = ST_OK; go_nxt = 10'(rd_gene); do_nxt = rd_dist;
        vld_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_START: begin
        cmd.clr_acc = 1'b1; elem_nxt = '0; state_nxt = S_RDA;
      end
      S_RDA: begin cmd.elem_rd = 1'b1; state_nxt = S_RDB; end
      S_RDB: state_nxt = S_ACC;
      S_ACC: begin
        cmd.sq_acc = 1'b1;
        elem_nxt = elem_r + 5'd1;
        state_nxt = (elem_r == 5'd5 || elem_r == 5'd11 || elem_r == 5'd17) ? S_RST : S_RDA;
      end
      S_RST: begin cmd.root_start = 1'b1; step_nxt = '0; state_nxt = S_ROOT; end
      S_ROOT: begin
        cmd.root_step = 1'b1; step_nxt = step_r + 5'd1;
        if (step_r == 5'd17) state_nxt = S_RADD;
      end
      S_RADD: begin
        cmd.root_add = 1'b1;
        if (elem_r == 5'd18) begin cmd.ins_start = 1'b1; state_nxt = S_IRD; end
        else state_nxt = S_RDA;
      end
      S_IRD: begin cmd.ins_rd = 1'b1; state_nxt = S_ICHK; end
      S_ICHK: begin
        if (sts.ins_stop) begin
          cmd.ins_put = 1'b1;
          if ((GW+1)'(gene_r) + 1'b1 == n_r) begin
            ranked_nxt = n_r; sorted_nxt = 1'b1; st_nxt = ST_OK;
            vld_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            gene_nxt = gene_r + 1'b1; state_nxt = S_START;
          end
        end else begin
          cmd.ins_shift = 1'b1; state_nxt = S_IRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sorted_r <= 1'b0; ranked_r <= '0; vld_r <= 1'b0;
      elem_r <= '0; step_r <= '0; gene_r <= '0; n_r <= '0;
    end else begin
      state_r <= state_nxt; sorted_r <= sorted_nxt; ranked_r <= ranked_nxt;
      vld_r <= vld_nxt; elem_r <= elem_nxt; step_r <= step_nxt;
      gene_r <= gene_nxt; n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt; go_r <= go_nxt; do_r <= do_nxt;
  end

  `GED_ASSERT_IMPL(a_ready_idle, req_ready, state_r == S_IDLE && !vld_r, "ready outside idle")
  `GED_ASSERT_NEXT(a_run_valid, state_r == S_ICHK && state_nxt == S_IDLE, sorted_r, "run end without sorted")
  `GED_ASSERT_IMPL(a_elem_range, state_r == S_RDA, elem_r < 5'd18, "element index out of range")
endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for grouped_euclidean_distance_ranker.
// Drives load, run and read requests on the in_ stream and checks every result
// on the out_ stream against a predictor held in this file; depends on ged_pkg.
`timescale 1ns / 1ps
module tb;
  import ged_pkg::*;

  localparam int NumItems = 1700;
  localparam int CycleLimit = 3000000;
  localparam int PreGenes = 32;

  // status in the lowest bits, as on out_tdata
  typedef struct packed {
    logic [18:0] distance;
    logic [9:0]  gene;
    logic [1:0]  st;
  } answer_t;

  typedef struct {
    bit          cfg;
    logic [9:0]  cref;
    logic [10:0] ccnt;
    logic [1:0]  req;
    logic [9:0]  gi;
    logic [1:0]  grp;
    logic [95:0] vals;
    logic [9:0]  rk;
    bit          typed;
    logic [1:0]  st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [10:0] cfg_wdata = '0;

  grouped_euclidean_distance_ranker uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] vec_mem [0:MaxItemsDef*ElemsPerGene-1];
  logic [18:0] rank_dist [0:MaxItemsDef-1];
  logic [9:0]  rank_gene [0:MaxItemsDef-1];
  bit          ranked;
  int          ranked_n;
  logic [9:0]  ref_gene;
  logic [10:0] gene_cnt;

  answer_t pending_answers [$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;
  answer_t got, want;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [18:0] summed_distance(int g, int r);
    longint unsigned total = 0;
    longint unsigned sq;
    longint signed diff;
    for (int grp = 0; grp < 3; grp++) begin
      sq = 0;
      for (int k = 0; k < 6; k++) begin
        diff = longint'($signed(vec_mem[g*ElemsPerGene + grp*6 + k]))
             - longint'($signed(vec_mem[r*ElemsPerGene + grp*6 + k]));
        sq += longint'(diff * diff);
      end
      total += int_sqrt(sq);
    end
    return (total > DistMax) ? DistMax : total[18:0];
  endfunction

  function automatic answer_t predict_answer(logic [119:0] d);
    answer_t a = '{st: ST_RANGE, gene: '0, distance: '0};
    int n, j;
    logic [18:0] dv;
    logic [9:0] gi = d[11:2];
    logic [1:0] grp = d[13:12];
    case (d[1:0])
      REQ_LOAD: begin
        if (grp < 3) begin
          for (int k = 0; k < 6; k++) vec_mem[gi*ElemsPerGene + grp*6 + k] = d[14 + 16*k +: 16];
          a.st = ST_OK;
        end
      end
      REQ_RUN: begin
        n = (gene_cnt > MaxItemsDef) ? MaxItemsDef : gene_cnt;
        if (ref_gene < n) begin
          for (int i = 0; i < n; i++) begin
            dv = summed_distance(i, ref_gene);
            j = i;
            while (j > 0 && rank_dist[j-1] > dv) begin
              rank_dist[j] = rank_dist[j-1];
              rank_gene[j] = rank_gene[j-1];
              j--;
            end
            rank_dist[j] = dv;
            rank_gene[j] = i[9:0];
          end
          ranked_n = n;
          ranked = 1'b1;
          a.st = ST_OK;
        end
      end
      REQ_READ: begin
        if (!ranked) begin
          a.st = ST_NOTRUN;
        end else if (d[119:110] < ranked_n) begin
          a.st = ST_OK;
          a.gene = rank_gene[d[119:110]];
          a.distance = rank_dist[d[119:110]];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, pending_answers.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[30:0];
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual st=%0d gene=%0d dist=%0d",
                 $realtime, got.st, got.gene, got.distance);
      end else begin
        want = pending_answers.pop_front();
        if (got.st !== want.st || got.gene !== want.gene || got.distance !== want.distance) begin
          errors++;
          $display("%0t: mismatch, expected st=%0d gene=%0d dist=%0d, actual st=%0d gene=%0d dist=%0d",
                   $realtime, want.st, want.gene, want.distance, got.st, got.gene, got.distance);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) out_tready <= quiet || ($urandom_range(99) >= 19);

  task automatic send_request(logic [119:0] d, bit typed, logic [1:0] st);
    answer_t a;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    a = predict_answer(d);
    if (typed) a = '{st: st, gene: '0, distance: '0};
    pending_answers.push_back(a);
    sent++;
  endtask

  // hold the sender until all answers are back, then write both registers
  task automatic set_registers(logic [9:0] r, logic [10:0] c);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REF;
    cfg_wdata <= {1'b0, r};
    @(negedge clk);
    cfg_index <= CFG_CNT;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    ref_gene = r;
    gene_cnt = c;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t mk(bit cfg, logic [9:0] cref, logic [10:0] ccnt, logic [1:0] req,
                              logic [9:0] gi, logic [1:0] grp, logic [95:0] vals,
                              logic [9:0] rk, bit typed, logic [1:0] st);
    return '{cfg, cref, ccnt, req, gi, grp, vals, rk, typed, st};
  endfunction

  row_t rows [$];
  logic [119:0] d;
  logic [95:0] vals;
  int n, pick, len;
  bit run_ok;

  initial begin
    ranked = 1'b0;
    ranked_n = 0;
    ref_gene = '0;
    gene_cnt = '0;
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 0, 1, ST_NOTRUN));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 0, 3, '1, 0, 1, ST_RANGE));
    rows.push_back(mk(0, 0, 0, 2'd3, 10'h3FF, 3, '1, 10'h3FF, 1, ST_RANGE));
    rows.push_back(mk(0, 0, 0, REQ_RUN, 0, 0, '0, 0, 1, ST_RANGE));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 0, 0, {6{16'h7FFF}}, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 0, 1, {6{16'h8000}}, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 0, 2, '0, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 1, 0, {6{16'h8000}}, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 1, 1, {6{16'h7FFF}}, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 1, 2, '1, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 2, 0, {3{32'h7FFF8000}}, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 2, 1, '0, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 2, 2, '0, 0, 1, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_LOAD, 10'h3FF, 2, '1, 0, 1, ST_OK));
    rows.push_back(mk(1, 0, 3, REQ_RUN, 0, 0, '0, 0, 0, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 0, 0, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 1, 0, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 2, 0, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 3, 1, ST_RANGE));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 10'h3FF, 1, ST_RANGE));
    rows.push_back(mk(1, 10'h3FF, 3, REQ_RUN, 0, 0, '0, 0, 1, ST_RANGE));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 1, 0, ST_OK));
    rows.push_back(mk(1, 2, 3, REQ_RUN, 0, 0, '0, 0, 0, ST_OK));
    rows.push_back(mk(0, 0, 0, REQ_READ, 0, 0, '0, 0, 0, ST_OK));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cfg) set_registers(rows[i].cref, rows[i].ccnt);
      send_request({rows[i].rk, rows[i].vals, rows[i].grp, rows[i].gi, rows[i].req},
                   rows[i].typed, rows[i].st);
    end

    // fill genes 3..31 so any run over the first PreGenes genes is legal
    for (int g = 3; g < PreGenes; g++) begin
      for (int grp = 0; grp < 3; grp++) begin
        for (int k = 0; k < 6; k++) vals[16*k +: 16] = pick_value();
        send_request({10'd0, vals, grp[1:0], g[9:0], REQ_LOAD}, 0, ST_OK);
      end
    end

    for (int ph = 0; sent < NumItems; ph++) begin
      quiet = (ph >= 6 && ph < 10);
      pick = $urandom_range(9);
      if (pick == 0) begin
        case ($urandom_range(2))
          0: set_registers(10'($urandom), 11'd0);
          1: set_registers(10'($urandom), 11'd1024);
          default: set_registers(10'($urandom), 11'h7FF);
        endcase
        run_ok = (gene_cnt == 0);
      end else if (pick == 1) begin
        n = $urandom_range(1, PreGenes);
        set_registers(10'($urandom_range(1023, n)), 11'(n));
        run_ok = 1'b1;
      end else begin
        n = ($urandom_range(4) == 0) ? PreGenes : $urandom_range(1, PreGenes);
        set_registers(10'($urandom_range(n - 1, 0)), 11'(n));
        run_ok = 1'b1;
      end
      len = $urandom_range(40, 80);
      for (int i = 0; i < len; i++) begin
        d = 120'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 35) begin
          d[1:0] = REQ_LOAD;
          d[11:2] = ($urandom_range(3) != 0) ? 10'($urandom_range(PreGenes - 1))
                                             : 10'($urandom);
          d[13:12] = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
          for (int k = 0; k < 6; k++) d[14 + 16*k +: 16] = pick_value();
        end else if (pick < 45 && run_ok) begin
          d[1:0] = REQ_RUN;
        end else if (pick < 92) begin
          d[1:0] = REQ_READ;
          if ($urandom_range(4) != 0) d[119:110] = 10'($urandom_range(39));
        end else begin
          d[1:0] = 2'd3;
        end
        send_request(d, 0, ST_OK);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/ged_pkg.sv
sv/ged_datapath.sv
sv/ged_ctrl.sv
sv/grouped_euclidean_distance_ranker.sv
test/tb.sv
